>>> rtl/c3sf_pkg.sv
`timescale 1ns / 1ps
package c3sf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_WIDTH  = 3;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int PIX_W    = 8;
    localparam int COEF_W   = 8;
    localparam int KROW_W   = 3 * COEF_W;
    localparam int LW_W     = 11;
    localparam int PROD_W   = PIX_W + COEF_W + 1;
    localparam int RSUM_W   = PROD_W + 2;
    localparam int CONV_W   = 20;
    localparam int POS_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W    = CONV_W + 2 * POS_W;
    localparam int CONV_MAX = 293760;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_TOP = 2'd0,
        CFG_KERNEL_MID = 2'd1,
        CFG_KERNEL_BOT = 2'd2,
        CFG_LINE_WIDTH = 2'd3
    } t_cfg_idx;

    typedef logic [PIX_W-1:0]          t_pix;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [RSUM_W-1:0]  t_rsum;

    function automatic logic signed [COEF_W-1:0] coef_at(
        input logic [KROW_W-1:0] row_reg,
        input int unsigned       k
    );
        coef_at = row_reg[k*COEF_W +: COEF_W];
    endfunction

endpackage

>>> rtl/conv3x3_stream_filter.sv
`timescale 1ns / 1ps
// 3x3 convolution over a raster image streamed one pixel per transaction.
// input stream: tdata carries the 8-bit unsigned pixel, tuser marks the first
//   pixel of a frame (clears the row and column counters before it is taken)
// output stream: one transaction per interior pixel, none for border pixels;
//   tdata holds the signed 20-bit sum, then the centre row and centre column
// config channel: index 0..2 load the top, middle and bottom kernel rows
//   (three signed bytes, left coefficient low), index 3 the line width
//   (values below 3 act as 3, above 1024 as 1024); write only while idle
// throughput: one pixel per cycle unless stalled; the two line stores share one 16-bit wide
//   single-port-read memory, read when a pixel is taken and written back as
//   that pixel leaves stage 1, with forwarding when the same column comes back at once
// path: line store read, window shift, products and row sums, then the output register
// stall: the pipeline freezes while the output register holds a result the
//   receiver does not take, and tready drops until it is taken
// reset: counters, window and kernel rows clear, line width returns to 1024;
//   line stores are not cleared and carry no meaning until a row is written
module conv3x3_stream_filter
    import c3sf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel
    input  logic                 s_axis_tuser,   // [0] frame_start
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata,   // [19:0] conv_value, [29:20] centre_row,
                                                 // [39:30] centre_col
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [KROW_W-1:0]    i_cfg_data
);

    // configuration
    logic [KROW_W-1:0] r_k_top, r_k_mid, r_k_bot;
    logic [LW_W-1:0]   r_line_width;
    logic [LW_W-1:0]   eff_width;
    logic [COL_W-1:0]  last_col;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_top      <= '0;
            r_k_mid      <= '0;
            r_k_bot      <= '0;
            r_line_width <= LW_W'(MAX_WIDTH);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_KERNEL_TOP: r_k_top      <= i_cfg_data;
                CFG_KERNEL_MID: r_k_mid      <= i_cfg_data;
                CFG_KERNEL_BOT: r_k_bot      <= i_cfg_data;
                CFG_LINE_WIDTH: r_line_width <= i_cfg_data[LW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_line_width < LW_W'(MIN_WIDTH)) begin
            eff_width = LW_W'(MIN_WIDTH);
        end else if (r_line_width > LW_W'(MAX_WIDTH)) begin
            eff_width = LW_W'(MAX_WIDTH);
        end else begin
            eff_width = r_line_width;
        end
    end

    assign last_col = COL_W'(eff_width - LW_W'(1));

    // handshake and position counters
    logic             en, acc;
    logic [COL_W-1:0] r_col_cnt, n_col_cnt, cur_col;
    logic [ROW_W-1:0] r_row_cnt, n_row_cnt, cur_row;
    logic             emit;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign acc           = s_axis_tvalid && en;

    assign cur_col = s_axis_tuser ? '0 : r_col_cnt;
    assign cur_row = s_axis_tuser ? '0 : r_row_cnt;
    assign emit    = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));

    always_comb begin
        n_col_cnt = r_col_cnt;
        n_row_cnt = r_row_cnt;
        if (acc) begin
            if (cur_col >= last_col) begin
                n_col_cnt = '0;
                n_row_cnt = (cur_row == ROW_W'(MAX_HEIGHT - 1)) ? '0 : cur_row + ROW_W'(1);
            end else begin
                n_col_cnt = cur_col + COL_W'(1);
                n_row_cnt = cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    // stage 1: line store read in flight
    logic                   r_s1_valid;
    logic                   r_s1_emit;
    t_pix                   r_s1_px;
    logic [COL_W-1:0]       r_s1_col;
    logic [POS_W-1:0]       r_s1_crow, r_s1_ccol;
    logic                   r_s1_fwd;
    logic [2*PIX_W-1:0]     r_s1_fwd_data;
    logic [2*PIX_W-1:0]     rd_data, col_data, wr_data;
    logic                   we;

    assign we       = en && r_s1_valid;
    assign col_data = r_s1_fwd ? r_s1_fwd_data : rd_data;
    assign wr_data  = {col_data[PIX_W-1:0], r_s1_px};

    c3sf_ram #(
        .WIDTH(2 * PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_s1_col),
        .i_wdata (wr_data),
        .i_re    (acc),
        .i_raddr (cur_col),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_emit     <= emit;
            r_s1_px       <= s_axis_tdata;
            r_s1_col      <= cur_col;
            r_s1_crow     <= POS_W'(cur_row - ROW_W'(1));
            r_s1_ccol     <= POS_W'(cur_col - COL_W'(1));
            r_s1_fwd      <= r_s1_valid && (r_s1_col == cur_col);
            r_s1_fwd_data <= wr_data;
        end
    end

    // stage 2: window shift
    t_pix             r_win [9];
    logic             r_s2_valid;
    logic [POS_W-1:0] r_s2_crow, r_s2_ccol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (we) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]     <= r_win[r*3 + 1];
                r_win[r*3 + 1] <= r_win[r*3 + 2];
            end
            r_win[2] <= col_data[2*PIX_W-1:PIX_W];
            r_win[5] <= col_data[PIX_W-1:0];
            r_win[8] <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_crow <= r_s1_crow;
            r_s2_ccol <= r_s1_ccol;
        end
    end

    // stage 3: nine products
    t_prod            r_prod [9];
    logic             r_s3_valid;
    logic [POS_W-1:0] r_s3_crow, r_s3_ccol;
    logic [KROW_W-1:0] krow [3];

    assign krow[0] = r_k_top;
    assign krow[1] = r_k_mid;
    assign krow[2] = r_k_bot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_crow <= r_s2_crow;
            r_s3_ccol <= r_s2_ccol;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[r*3 + k] <= PROD_W'($signed({1'b0, r_win[r*3 + k]})
                                               * coef_at(krow[r], k));
                end
            end
        end
    end

    // stage 4: row sums
    t_rsum            r_rsum [3];
    logic             r_s4_valid;
    logic [POS_W-1:0] r_s4_crow, r_s4_ccol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_crow <= r_s3_crow;
            r_s4_ccol <= r_s3_ccol;
            for (int r = 0; r < 3; r++) begin
                r_rsum[r] <= RSUM_W'(r_prod[r*3]) + RSUM_W'(r_prod[r*3 + 1])
                             + RSUM_W'(r_prod[r*3 + 2]);
            end
        end
    end

    // output register
    logic                     r_out_valid;
    logic signed [CONV_W-1:0] r_out_conv;
    logic [POS_W-1:0]         r_out_crow, r_out_ccol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_conv <= CONV_W'(r_rsum[0]) + CONV_W'(r_rsum[1]) + CONV_W'(r_rsum[2]);
            r_out_crow <= r_s4_crow;
            r_out_ccol <= r_s4_ccol;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_ccol, r_out_crow, r_out_conv};

`ifndef SYNTHESIS
    a_centre_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out_crow != '0) && (r_out_ccol != '0))
        else $error("result centre lies on the frame border");

    a_conv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out_conv <= CONV_W'(CONV_MAX))
                          && (r_out_conv >= -CONV_W'(CONV_MAX)))
        else $error("convolution sum out of range");

    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_s4_valid))
        else $error("result appeared without a row-sum stage entry");

    a_fwd_only_on_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_s1_valid && (cur_col == r_s1_col)) |=> r_s1_fwd)
        else $error("repeated column read missed forwarding");
`endif

endmodule

>>> rtl/c3sf_ram.sv
`timescale 1ns / 1ps
module c3sf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
